>>> hw/rtl/fraction_reduce_and_compare_assert.svh
// ----------------------------------------------------------------------------
// fraction_reduce_and_compare assertion macros
// shared property wrappers for the fraction reduce and compare block
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_AND_COMPARE_ASSERT_SVH
`define FRACTION_REDUCE_AND_COMPARE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frc assertion failed");

// consequent must hold in the cycle after the antecedent
`define FRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frc assertion failed");

`endif

>>> hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// widths, stream layout and controller/datapath command types
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int DW         = 32;
    localparam int NUM_FIELDS = 4;
    localparam int CNT_W      = $clog2(DW);
    localparam int K_W        = $clog2(DW);
    localparam int PROD_W     = 2 * DW;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W  = ((NUM_FIELDS * DW + 7) / 8) * 8;
    localparam int M_FIELD_W  = NUM_FIELDS * DW + 3;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELD_W;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic fix;
        logic mul;
        logic out_load;
    } frc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic gcd_done;
    } frc_sts_t;

endpackage

>>> hw/rtl/frc_ctrl.sv
// ----------------------------------------------------------------------------
// frc_ctrl
// sequencer for load, gcd, division, sign fix, multiply and result transfer
// ----------------------------------------------------------------------------
`include "fraction_reduce_and_compare_assert.svh"

module frc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output frc_pkg::frc_cmd_t cmd_o,
    input  frc_pkg::frc_sts_t sts_i
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_GCD  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_FIX  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam logic [frc_pkg::CNT_W-1:0] CNT_LAST = frc_pkg::CNT_W'(frc_pkg::DW - 1);

    state_t                    state_reg, state_next;
    logic [frc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_o      = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (sts_i.gcd_done) begin
                    cmd_o.div_init = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_DIV;
                end else begin
                    cmd_o.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd_o.div_step = 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIX: begin
                cmd_o.fix  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd_o.mul  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd_o.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // checks
    `FRC_ASSERT_NEXT(a_load_starts_gcd, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_GCD)
    `FRC_ASSERT_NEXT(a_div_ends, aclk, aresetn, state_reg == ST_DIV && cnt_reg == CNT_LAST, state_reg == ST_FIX)
    `FRC_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd_o.out_load, !out_valid_reg || m_tready)
    `FRC_ASSERT_NEXT(a_load_shows, aclk, aresetn, cmd_o.out_load, m_tvalid)

endmodule

>>> hw/rtl/frc_dp.sv
// ----------------------------------------------------------------------------
// frc_dp
// magnitude split, two binary gcd lanes, four restoring divider lanes,
// sign restore, cross products and the result register
// ----------------------------------------------------------------------------
module frc_dp (
    input  logic                                   aclk,
    input  frc_pkg::frc_cmd_t                      cmd_i,
    output frc_pkg::frc_sts_t                      sts_o,
    input  logic [frc_pkg::NUM_FIELDS*frc_pkg::DW-1:0] in_data,
    output logic [frc_pkg::NUM_FIELDS*frc_pkg::DW-1:0] out_red,
    output logic                                   out_equal,
    output logic                                   out_less,
    output logic                                   out_greater
);

    localparam int DW = frc_pkg::DW;
    localparam int NF = frc_pkg::NUM_FIELDS;

    logic [DW-1:0]             mag_reg [NF];
    logic [NF-1:0]             sgn_reg;
    logic [DW-1:0]             gx_reg [2], gx_next [2];
    logic [DW-1:0]             gy_reg [2], gy_next [2];
    logic [frc_pkg::K_W-1:0]   k_reg  [2], k_next  [2];
    logic [DW-1:0]             g_reg  [2];
    logic [DW-1:0]             q_reg  [NF], q_next [NF];
    logic [DW-1:0]             r_reg  [NF], r_next [NF];
    logic signed [DW-1:0]      red_reg [NF];
    logic signed [frc_pkg::PROD_W-1:0] prod_l_reg, prod_r_reg;
    logic [NF*DW-1:0]          out_red_reg;
    logic                      out_equal_reg, out_less_reg, out_greater_reg;
    logic [1:0]                lane_done;

    // binary gcd step per fraction
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            lane_done[i] = (gx_reg[i] == '0) || (gy_reg[i] == '0);
            gx_next[i]   = gx_reg[i];
            gy_next[i]   = gy_reg[i];
            k_next[i]    = k_reg[i];
            if (!lane_done[i]) begin
                if (!gx_reg[i][0] && !gy_reg[i][0]) begin
                    gx_next[i] = gx_reg[i] >> 1;
                    gy_next[i] = gy_reg[i] >> 1;
                    k_next[i]  = k_reg[i] + 1'b1;
                end else if (!gx_reg[i][0]) begin
                    gx_next[i] = gx_reg[i] >> 1;
                end else if (!gy_reg[i][0]) begin
                    gy_next[i] = gy_reg[i] >> 1;
                end else if (gx_reg[i] >= gy_reg[i]) begin
                    gx_next[i] = gx_reg[i] - gy_reg[i];
                end else begin
                    gy_next[i] = gy_reg[i] - gx_reg[i];
                end
            end
        end
    end

    assign sts_o.gcd_done = &lane_done;

    // restoring division step per field, divisor is its fraction's gcd
    always_comb begin
        for (int j = 0; j < NF; j++) begin
            logic [DW-1:0] r_sh;
            r_sh      = {r_reg[j][DW-2:0], q_reg[j][DW-1]};
            q_next[j] = {q_reg[j][DW-2:0], 1'b0};
            r_next[j] = r_sh;
            if (r_sh >= g_reg[j/2]) begin
                r_next[j] = r_sh - g_reg[j/2];
                q_next[j][0] = 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        // split into sign and magnitude, seed gcd lanes
        if (cmd_i.load) begin
            for (int j = 0; j < NF; j++) begin
                logic [DW-1:0] v;
                v          = in_data[j*DW +: DW];
                sgn_reg[j] <= v[DW-1];
                mag_reg[j] <= v[DW-1] ? (~v + 1'b1) : v;
            end
            for (int i = 0; i < 2; i++) begin
                logic [DW-1:0] vn, vd;
                vn = in_data[(2*i)*DW +: DW];
                vd = in_data[(2*i+1)*DW +: DW];
                gx_reg[i] <= vn[DW-1] ? (~vn + 1'b1) : vn;
                gy_reg[i] <= vd[DW-1] ? (~vd + 1'b1) : vd;
                k_reg[i]  <= '0;
            end
        end else if (cmd_i.gcd_step) begin
            for (int i = 0; i < 2; i++) begin
                gx_reg[i] <= gx_next[i];
                gy_reg[i] <= gy_next[i];
                k_reg[i]  <= k_next[i];
            end
        end

        // gcd result and divider seed
        if (cmd_i.div_init) begin
            for (int i = 0; i < 2; i++) begin
                g_reg[i] <= (gx_reg[i] | gy_reg[i]) << k_reg[i];
            end
            for (int j = 0; j < NF; j++) begin
                q_reg[j] <= mag_reg[j];
                r_reg[j] <= '0;
            end
        end else if (cmd_i.div_step) begin
            for (int j = 0; j < NF; j++) begin
                q_reg[j] <= q_next[j];
                r_reg[j] <= r_next[j];
            end
        end

        // restore signs, zero over zero keeps its magnitudes
        if (cmd_i.fix) begin
            for (int j = 0; j < NF; j++) begin
                logic [DW-1:0] m;
                m          = (g_reg[j/2] == '0) ? mag_reg[j] : q_reg[j];
                red_reg[j] <= sgn_reg[j] ? $signed(~m + 1'b1) : $signed(m);
            end
        end

        // cross products
        if (cmd_i.mul) begin
            prod_l_reg <= red_reg[0] * red_reg[3];
            prod_r_reg <= red_reg[2] * red_reg[1];
        end

        // result register
        if (cmd_i.out_load) begin
            for (int j = 0; j < NF; j++) begin
                out_red_reg[j*DW +: DW] <= red_reg[j];
            end
            out_equal_reg   <= (red_reg[0] == red_reg[2]) && (red_reg[1] == red_reg[3]);
            out_less_reg    <= prod_l_reg < prod_r_reg;
            out_greater_reg <= prod_r_reg < prod_l_reg;
        end
    end

    assign out_red     = out_red_reg;
    assign out_equal   = out_equal_reg;
    assign out_less    = out_less_reg;
    assign out_greater = out_greater_reg;

endmodule

>>> hw/rtl/fraction_reduce_and_compare.sv
// ----------------------------------------------------------------------------
// fraction_reduce_and_compare
// reduces two signed fractions by the gcd of their magnitudes and compares
// the reduced fractions by exact cross products
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  --------+--------------------------------+---------------------------------
//  input   | s_tvalid s_tready s_tdata[127:0] | num_a den_a num_b den_b
//  result  | m_tvalid m_tready m_tdata[135:0] | reduced parts, equal/less/greater
//
//  one item at a time: a load, binary gcd (both fractions in parallel),
//  restoring division (all four parts in parallel), then sign restore,
//  multiply and result load; the worst case is set by the gcd loop and the
//  one-bit-per-cycle divider.
//  the result register lets a new transfer in while the last result waits.
//  reset (aresetn low, synchronous) empties the result register and idles.
// ----------------------------------------------------------------------------
module fraction_reduce_and_compare (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // num_a [31:0], den_a [63:32], num_b [95:64], den_b [127:96]
    input  logic [frc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_num_a [31:0], red_den_a [63:32], red_num_b [95:64], red_den_b [127:96],
    // is_equal [128], is_less [129], is_greater [130], zero [135:131]
    output logic [frc_pkg::M_TDATA_W-1:0]   m_tdata
);

    frc_pkg::frc_cmd_t cmd;
    frc_pkg::frc_sts_t sts;
    logic [frc_pkg::NUM_FIELDS*frc_pkg::DW-1:0] red;
    logic is_equal, is_less, is_greater;

    // sequencer
    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd_o    (cmd),
        .sts_i    (sts)
    );

    // arithmetic
    frc_dp u_dp (
        .aclk        (aclk),
        .cmd_i       (cmd),
        .sts_o       (sts),
        .in_data     (s_tdata[frc_pkg::NUM_FIELDS*frc_pkg::DW-1:0]),
        .out_red     (red),
        .out_equal   (is_equal),
        .out_less    (is_less),
        .out_greater (is_greater)
    );

    // result packing
    assign m_tdata = {{frc_pkg::M_PAD_W{1'b0}}, is_greater, is_less, is_equal, red};

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for fraction_reduce_and_compare. Each pair of fractions
// is scored against a table or a local model of the gcd reduction and the
// cross-product compare. A short directed table comes first and covers zero
// over zero, zero denominators, the most negative value and sign mixes.
// Random pairs with shared factors and scaled copies follow, while both sides
// idle at random and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW             = frc_pkg::DW;
    localparam int RANDOM_PAIRS   = 2000;
    localparam int QUIET_FIRST    = 900;     // no idling on either side in this span
    localparam int QUIET_LAST     = 1200;
    localparam int HOLD_AT        = 300;     // receiver hold-off starts here
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [DW-1:0] MIN_F = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MAX_F = {1'b0, {(DW-1){1'b1}}};

    // input fields, num_a in the lowest bits as on s_tdata
    typedef struct packed {
        logic [DW-1:0] den_b;
        logic [DW-1:0] num_b;
        logic [DW-1:0] den_a;
        logic [DW-1:0] num_a;
    } frac_pair_t;

    // result fields, red_num_a in the lowest bits as on m_tdata
    typedef struct packed {
        logic          is_greater;
        logic          is_less;
        logic          is_equal;
        logic [DW-1:0] red_den_b;
        logic [DW-1:0] red_num_b;
        logic [DW-1:0] red_den_a;
        logic [DW-1:0] red_num_a;
    } frac_result_t;

    // directed row: the result is typed in only when known is set
    typedef struct packed {
        frac_pair_t   pair;
        logic         known;
        frac_result_t want;
    } directed_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [frc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [frc_pkg::M_TDATA_W-1:0] m_tdata;

    frac_result_t  expected_reductions[$];
    directed_row_t directed[$];
    int            pairs_sent = 0;
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    fraction_reduce_and_compare DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // reduce one fraction in place by the gcd of the magnitudes
    function automatic void reduce_fraction(inout longint n, inout longint d);
        longint unsigned x, y, t;
        x = (n < 0) ? longint'(-n) : longint'(n);
        y = (d < 0) ? longint'(-d) : longint'(d);
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        // 0/0 passes through unchanged
        if (x != 0) begin
            n = n / longint'(x);
            d = d / longint'(x);
        end
    endfunction

    function automatic frac_result_t reduce_and_compare(frac_pair_t p);
        longint       na, da, nb, db, left, right;
        frac_result_t r;
        na = longint'($signed(p.num_a));
        da = longint'($signed(p.den_a));
        nb = longint'($signed(p.num_b));
        db = longint'($signed(p.den_b));
        reduce_fraction(na, da);
        reduce_fraction(nb, db);
        // products stay within 2^62, exact in 64 bits
        left  = na * db;
        right = nb * da;
        r.red_num_a  = na[DW-1:0];
        r.red_den_a  = da[DW-1:0];
        r.red_num_b  = nb[DW-1:0];
        r.red_den_b  = db[DW-1:0];
        r.is_equal   = (na == nb) && (da == db);
        r.is_less    = left < right;
        r.is_greater = right < left;
        return r;
    endfunction

    function automatic frac_pair_t pair_of(logic [DW-1:0] na, da, nb, db);
        return '{num_a: na, den_a: da, num_b: nb, den_b: db};
    endfunction

    function automatic frac_result_t result_of(logic [DW-1:0] na, da, nb, db,
                                                int eq, lt, gt);
        return '{is_greater: gt[0], is_less: lt[0], is_equal: eq[0], red_den_b: db,
                 red_num_b: nb, red_den_a: da, red_num_a: na};
    endfunction

    function automatic logic [DW-1:0] small_int(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mix of full-range, small, extreme and mid-size values
    function automatic logic [DW-1:0] random_field();
        logic [DW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = small_int(32);
            2: begin
                case ($urandom_range(0, 5))
                    0: v = MIN_F;
                    1: v = MAX_F;
                    2: v = '0;
                    3: v = 1;
                    4: v = '1;
                    default: v = MIN_F + 1;
                endcase
            end
            default: begin
                v = $urandom() >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic frac_pair_t random_pair();
        frac_pair_t    p;
        logic [DW-1:0] g, k;
        p.num_a = random_field();
        p.den_a = random_field();
        p.num_b = random_field();
        p.den_b = random_field();
        case ($urandom_range(0, 9))
            // shared factor inside each fraction
            3, 4, 5, 6: begin
                g = $urandom() >> $urandom_range(4, 31);
                p.num_a = small_int(40) * g;
                p.den_a = small_int(40) * g;
                g = $urandom() >> $urandom_range(4, 31);
                p.num_b = small_int(40) * g;
                p.den_b = small_int(40) * g;
            end
            // b is a scaled copy of a, sign flip included
            7, 8, 9: begin
                g = $urandom() >> $urandom_range(8, 31);
                p.num_a = small_int(40) * g;
                p.den_a = small_int(40) * g;
                k = small_int(6);
                if (k == 0) k = 1;
                p.num_b = p.num_a * k;
                p.den_b = p.den_a * k;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic bit idling_allowed();
        return (pairs_sent < QUIET_FIRST) || (pairs_sent >= QUIET_LAST);
    endfunction

    task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    // offer one pair and wait for its transfer
    task automatic send_pair(frac_pair_t pair, frac_result_t want);
        while (idling_allowed() && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        do @(posedge aclk); while (!s_tready);
        expected_reductions.push_back(want);
        pairs_sent++;
        @(negedge aclk);
    endtask

    // receiver: random idling plus one long hold-off
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && pairs_sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !(idling_allowed() && $urandom_range(0, 99) < 21);
        end
    end

    // score each result transfer against the oldest expectation
    always @(posedge aclk) begin
        frac_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = frac_result_t'(m_tdata[frc_pkg::M_FIELD_W-1:0]);
            if (expected_reductions.size() == 0) begin
                $error("result transfer with no pair outstanding");
                mismatches++;
            end else begin
                want = expected_reductions.pop_front();
                check_field("red_num_a", want.red_num_a, got.red_num_a);
                check_field("red_den_a", want.red_den_a, got.red_den_a);
                check_field("red_num_b", want.red_num_b, got.red_num_b);
                check_field("red_den_b", want.red_den_b, got.red_den_b);
                check_field("is_equal", DW'(want.is_equal), DW'(got.is_equal));
                check_field("is_less", DW'(want.is_less), DW'(got.is_less));
                check_field("is_greater", DW'(want.is_greater), DW'(got.is_greater));
                check_field("pad", '0,
                            DW'(m_tdata[frc_pkg::M_TDATA_W-1:frc_pkg::M_FIELD_W]));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        frac_pair_t p;

        // zero over zero on both sides
        directed.push_back('{pair_of(0, 0, 0, 0), 1'b1, result_of(0, 0, 0, 0, 1, 0, 0)});
        // most negative over zero, zero over zero
        directed.push_back('{pair_of(MIN_F, 0, 0, 0), 1'b1,
                             result_of(-1, 0, 0, 0, 0, 0, 0)});
        // most negative over itself
        directed.push_back('{pair_of(MIN_F, MIN_F, MIN_F, MIN_F), 1'b1,
                             result_of(-1, -1, -1, -1, 1, 0, 0)});
        directed.push_back('{pair_of(MAX_F, MAX_F, 1, 1), 1'b1,
                             result_of(1, 1, 1, 1, 1, 0, 0)});
        directed.push_back('{pair_of(6, 4, 3, 2), 1'b1, result_of(3, 2, 3, 2, 1, 0, 0)});
        // nonzero over zero
        directed.push_back('{pair_of(5, 0, -7, 0), 1'b1, result_of(1, 0, -1, 0, 0, 0, 0)});
        directed.push_back('{pair_of(1, 2, 1, 3), 1'b1, result_of(1, 2, 1, 3, 0, 0, 1)});
        // same value, sign on different parts
        directed.push_back('{pair_of(-1, 2, 1, -2), 1'b1, result_of(-1, 2, 1, -2, 0, 0, 0)});
        // zero over nonzero
        directed.push_back('{pair_of(0, 5, 0, -3), 1'b1, result_of(0, 1, 0, -1, 0, 0, 0)});
        directed.push_back('{pair_of(-1, -1, 1, 1), 1'b1, result_of(-1, -1, 1, 1, 0, 0, 0)});
        directed.push_back('{pair_of(32'h4000_0000, 32'h2000_0000, 6, 3), 1'b1,
                             result_of(2, 1, 2, 1, 1, 0, 0)});
        directed.push_back('{pair_of(MIN_F + 1, MAX_F, 1, -1), 1'b1,
                             result_of(-1, 1, 1, -1, 0, 0, 0)});
        directed.push_back('{pair_of(MAX_F, MIN_F, MIN_F, MAX_F), 1'b0, '0});
        directed.push_back('{pair_of(MAX_F, 1, MIN_F, 1), 1'b0, '0});
        directed.push_back('{pair_of(MIN_F, 1, MAX_F, -1), 1'b0, '0});
        directed.push_back('{pair_of(1, MIN_F, -1, MAX_F), 1'b0, '0});
        directed.push_back('{pair_of(MIN_F, 3, 3, MIN_F), 1'b0, '0});
        directed.push_back('{pair_of(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                                     32'h5555_5555), 1'b0, '0});
        directed.push_back('{pair_of(32'h7fff_fffe, 32'h7fff_fffc, -3, 4), 1'b0, '0});
        directed.push_back('{pair_of(-3, 4, 1, 4), 1'b0, '0});
        directed.push_back('{pair_of(46341 * 3, 46341 * 7, -9, -21), 1'b0, '0});

        // hold reset, then release it at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].known ? directed[i].want
                                                          : reduce_and_compare(directed[i].pair));
        repeat (RANDOM_PAIRS) begin
            p = random_pair();
            send_pair(p, reduce_and_compare(p));
        end
        s_tvalid <= 1'b0;

        // drain, then wait DRAIN_CYCLES more for stray results
        while (expected_reductions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
